[rtl/tmcw_pkg.sv]
// ----------------------------------------------------------------------------
// tmcw_pkg: shared definitions of the text mode console writer
// Screen geometry, command and operation codes, word types and the
// decoded command that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  // Source index during a sweep reaches below twice the store size.
  localparam int SUM_W  = $clog2(2 * CELLS);

  localparam logic [7:0]  BLANK_ATTR = 8'h07;
  localparam logic [7:0]  BLANK_CHAR = 8'h00;
  localparam logic [15:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};

  // Depth of the queues between the parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_LOCATE = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_ROLL   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_LOCATE,
    OP_CLEAR,
    OP_ROLL,
    OP_READ,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] roll_rows;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_offset;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        status;
  } out_word_t;

  typedef struct packed {
    op_e               op;
    logic [7:0]        char_code;
    logic [7:0]        attribute;
    logic              pos_ok;
    logic [4:0]        row;
    logic [6:0]        col;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  shift;
  } dec_t;

endpackage

[rtl/tmcw_front.sv]
// ----------------------------------------------------------------------------
// tmcw_front: command classifier
// Turns an incoming word into an operation code, checks the target position
// and works out the cell address and the sweep distance of a roll or clear.
// ----------------------------------------------------------------------------
module tmcw_front (
  input  tmcw_pkg::in_word_t in_word_i,
  output tmcw_pkg::dec_t     dec_o
);

  int n_clamp;

  always_comb begin
    n_clamp = (int'(in_word_i.roll_rows) >= tmcw_pkg::ROWS) ? tmcw_pkg::ROWS
                                                            : int'(in_word_i.roll_rows);
    dec_o.char_code = in_word_i.char_code;
    dec_o.attribute = in_word_i.attribute;
    dec_o.row       = in_word_i.row;
    dec_o.col       = in_word_i.col;
    dec_o.pos_ok    = (int'(in_word_i.row) < tmcw_pkg::ROWS) &&
                      (int'(in_word_i.col) < tmcw_pkg::COLS);
    dec_o.addr      = tmcw_pkg::ADDR_W'(int'(in_word_i.row) * tmcw_pkg::COLS +
                                        int'(in_word_i.col));
    dec_o.shift     = tmcw_pkg::SUM_W'(n_clamp * tmcw_pkg::COLS);
    case (in_word_i.command)
      tmcw_pkg::CMD_WRITE:  dec_o.op = tmcw_pkg::OP_WRITE;
      tmcw_pkg::CMD_LOCATE: dec_o.op = tmcw_pkg::OP_LOCATE;
      tmcw_pkg::CMD_CLEAR: begin
        dec_o.op    = tmcw_pkg::OP_CLEAR;
        dec_o.shift = tmcw_pkg::SUM_W'(tmcw_pkg::CELLS);
      end
      tmcw_pkg::CMD_ROLL:   dec_o.op = tmcw_pkg::OP_ROLL;
      tmcw_pkg::CMD_READ:   dec_o.op = tmcw_pkg::OP_READ;
      default:              dec_o.op = tmcw_pkg::OP_BAD;
    endcase
  end

endmodule

[rtl/tmcw_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tmcw_cmd_fifo: command queue
// Short queue of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module tmcw_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tmcw_pkg::dec_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tmcw_pkg::dec_t data_o,
  output logic           empty_o
);

  tmcw_pkg::dec_t                      slot_q [tmcw_pkg::QDEPTH];
  logic [tmcw_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tmcw_pkg::QCNT_W-1:0]         count_q, count_d;
  logic                                do_push, do_pop;

  assign full_o  = (count_q == tmcw_pkg::QCNT_W'(tmcw_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tmcw_pkg::QPTR_W'(tmcw_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tmcw_pkg::QPTR_W'(tmcw_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/tmcw_res_fifo.sv]
// ----------------------------------------------------------------------------
// tmcw_res_fifo: result queue
// Short queue of result words that parts the back end from the consumer.
// ----------------------------------------------------------------------------
module tmcw_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tmcw_pkg::out_word_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output tmcw_pkg::out_word_t data_o,
  output logic                empty_o
);

  tmcw_pkg::out_word_t                 slot_q [tmcw_pkg::QDEPTH];
  logic [tmcw_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tmcw_pkg::QCNT_W-1:0]         count_q, count_d;
  logic                                do_push, do_pop;

  assign full_o  = (count_q == tmcw_pkg::QCNT_W'(tmcw_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tmcw_pkg::QPTR_W'(tmcw_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tmcw_pkg::QPTR_W'(tmcw_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/tmcw_back.sv]
// ----------------------------------------------------------------------------
// tmcw_back: command execution
// Holds the cursor and the cell store, runs one command at a time and
// sweeps the store for clear and roll up.
// ----------------------------------------------------------------------------
module tmcw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmcw_pkg::dec_t      cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output tmcw_pkg::out_word_t res_o
);

  logic [15:0]                 cell_mem [tmcw_pkg::CELLS];
  logic [15:0]                 rdata_q;
  logic                        we;
  logic [tmcw_pkg::ADDR_W-1:0] waddr, raddr;
  logic [15:0]                 wdata;

  tmcw_pkg::state_e            state_q, state_d;
  logic [4:0]                  cur_row_q, cur_row_d;
  logic [6:0]                  cur_col_q, cur_col_d;
  logic [tmcw_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic [tmcw_pkg::SUM_W-1:0]  shift_q, shift_d;
  logic                        clr_q, clr_d;
  logic                        pend_q, pend_d;
  logic                        pend_copy_q, pend_copy_d;
  logic [tmcw_pkg::ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [tmcw_pkg::SUM_W-1:0]  src;
  logic [7:0]                  rd_char, rd_attr;
  logic                        status;

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    clr_d       = clr_q;
    pend_d      = 1'b0;
    pend_copy_d = 1'b0;
    pend_addr_d = pend_addr_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    rd_char     = '0;
    rd_attr     = '0;
    status      = 1'b0;
    src         = tmcw_pkg::SUM_W'(idx_q) + shift_q;

    // A cell fetched in the previous sweep cycle is written back now.
    if (pend_q) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      wdata = pend_copy_q ? rdata_q : tmcw_pkg::BLANK_CELL;
    end

    case (state_q)
      tmcw_pkg::ST_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            tmcw_pkg::OP_WRITE: begin
              we    = 1'b1;
              waddr = tmcw_pkg::ADDR_W'(int'(cur_row_q) * tmcw_pkg::COLS + int'(cur_col_q));
              wdata = {cmd_i.attribute, cmd_i.char_code};
              if (cur_col_q == 7'(tmcw_pkg::COLS - 1)) begin
                cur_col_d = '0;
                cur_row_d = (cur_row_q == 5'(tmcw_pkg::ROWS - 1)) ? '0 : cur_row_q + 1'b1;
              end else begin
                cur_col_d = cur_col_q + 1'b1;
              end
              res_push_o = 1'b1;
            end
            tmcw_pkg::OP_LOCATE: begin
              if (cmd_i.pos_ok) begin
                cur_row_d = cmd_i.row;
                cur_col_d = cmd_i.col;
              end else begin
                status = 1'b1;
              end
              res_push_o = 1'b1;
            end
            tmcw_pkg::OP_CLEAR, tmcw_pkg::OP_ROLL: begin
              if (cmd_i.shift == '0) begin
                // Roll by zero moves only the cursor.
                cur_row_d  = 5'(tmcw_pkg::ROWS - 1);
                res_push_o = 1'b1;
              end else begin
                idx_d   = '0;
                shift_d = cmd_i.shift;
                clr_d   = (cmd_i.op == tmcw_pkg::OP_CLEAR);
                state_d = tmcw_pkg::ST_SWEEP;
              end
            end
            tmcw_pkg::OP_READ: begin
              if (cmd_i.pos_ok) begin
                raddr   = cmd_i.addr;
                state_d = tmcw_pkg::ST_READ_WAIT;
              end else begin
                status     = 1'b1;
                res_push_o = 1'b1;
              end
            end
            default: begin
              status     = 1'b1;
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      tmcw_pkg::ST_READ_WAIT: begin
        rd_char    = rdata_q[7:0];
        rd_attr    = rdata_q[15:8];
        res_push_o = 1'b1;
        state_d    = tmcw_pkg::ST_IDLE;
      end
      tmcw_pkg::ST_SWEEP: begin
        pend_d      = 1'b1;
        pend_addr_d = idx_q;
        if (src < tmcw_pkg::SUM_W'(tmcw_pkg::CELLS)) begin
          raddr       = src[tmcw_pkg::ADDR_W-1:0];
          pend_copy_d = 1'b1;
        end
        if (idx_q == tmcw_pkg::ADDR_W'(tmcw_pkg::CELLS - 1)) begin
          state_d = tmcw_pkg::ST_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      tmcw_pkg::ST_FINISH: begin
        if (clr_q) begin
          cur_row_d = '0;
          cur_col_d = '0;
        end else begin
          cur_row_d = 5'(tmcw_pkg::ROWS - 1);
        end
        res_push_o = 1'b1;
        state_d    = tmcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = tmcw_pkg::ST_IDLE;
      end
    endcase

    res_o.cursor_row    = cur_row_d;
    res_o.cursor_col    = cur_col_d;
    res_o.cursor_offset = 11'(int'(cur_row_d) * tmcw_pkg::COLS + int'(cur_col_d));
    res_o.read_char     = rd_char;
    res_o.read_attr     = rd_attr;
    res_o.status        = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tmcw_pkg::ST_IDLE;
      cur_row_q <= '0;
      cur_col_q <= '0;
      idx_q     <= '0;
      shift_q   <= '0;
      clr_q     <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      idx_q     <= idx_d;
      shift_q   <= shift_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_copy_q <= pend_copy_d;
    pend_addr_q <= pend_addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cell_mem[waddr] <= wdata;
    end
    rdata_q <= cell_mem[raddr];
  end

  // The result queue is checked for room before a command starts.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == tmcw_pkg::ST_IDLE))
    else $error("command taken while another is running");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cur_col_q) < tmcw_pkg::COLS) && (int'(cur_row_q) < tmcw_pkg::ROWS))
    else $error("cursor left the screen");

  a_finish_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmcw_pkg::ST_FINISH) |-> pend_q ##1 (state_q == tmcw_pkg::ST_IDLE && !pend_q))
    else $error("sweep ended without its last write");

endmodule

[rtl/text_mode_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit: character-cell text screen with a cursor
// Write, locate, out-of-range read and roll by zero answer from the idle
// state; an in-range read answers from a read-wait state after the store read.
// Throughput: one word per cycle for write and locate while the result queue
// has room; a read holds off the next command until it answers; clear and
// roll up sweep the store, one cell per cycle, in the execution unit.
// Reset clears the cursor and both queues; the cell store is not cleared.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command side, a queue write port.
  input  logic                push,
  input  tmcw_pkg::in_word_t  in_word_i,
  output logic                full,
  // Result side, a queue read port.
  output logic                empty,
  input  logic                pop,
  output tmcw_pkg::out_word_t out_word_o
);

  // The front end classifies each word as it arrives. Decoded commands wait
  // in a short queue so that input words keep flowing while the back end is
  // busy with a sweep or a read.
  tmcw_pkg::dec_t dec_in;
  tmcw_pkg::dec_t dec_out;
  logic           cmd_empty;
  logic           cmd_pop;

  tmcw_front u_front (
    .in_word_i (in_word_i),
    .dec_o     (dec_in)
  );

  tmcw_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (dec_out),
    .empty_o (cmd_empty)
  );

  // The back end owns the cursor and the cell store. It starts a command
  // only when the result queue has room, so a finished word never stalls it.
  tmcw_pkg::out_word_t res_word;
  logic                res_push;
  logic                res_full;

  tmcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dec_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  // Result words wait here until the consumer pops them.
  tmcw_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text mode console writer
// Drives command words through the push/full side, pops result words on the
// empty/pop side and compares every field against a cycle-free screen model
// that tracks the cell store and the cursor.
// ----------------------------------------------------------------------------

import tmcw_pkg::*;

// Screen model and the queue of result words still owed by the block.
class screen_scoreboard;

  logic [15:0] cells [CELLS];
  // Cells whose content is defined, by a write, a clear or a roll blank.
  bit          defined [CELLS];
  int          cur_row;
  int          cur_col;
  out_word_t   owed_results [$];
  int unsigned mismatches;

  function new();
    foreach (cells[i]) begin
      cells[i]   = '0;
      defined[i] = 1'b0;
    end
    cur_row    = 0;
    cur_col    = 0;
    mismatches = 0;
  endfunction

  task report(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function bit cell_defined(int r, int c);
    return defined[r * COLS + c];
  endfunction

  // Applies one command to the model and returns the result word it owes.
  function out_word_t apply_command(in_word_t w);
    out_word_t res;
    int        n;
    int        idx;
    res = '0;
    case (w.command)
      CMD_WRITE: begin
        idx          = cur_row * COLS + cur_col;
        cells[idx]   = {w.attribute, w.char_code};
        defined[idx] = 1'b1;
        cur_col++;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        // The screen wraps to the top instead of scrolling.
        if (cur_row >= ROWS) begin
          cur_row = 0;
        end
      end
      CMD_LOCATE: begin
        if (w.row >= ROWS || w.col >= COLS) begin
          res.status = 1'b1;
        end else begin
          cur_row = w.row;
          cur_col = w.col;
        end
      end
      CMD_CLEAR: begin
        foreach (cells[i]) begin
          cells[i]   = BLANK_CELL;
          defined[i] = 1'b1;
        end
        cur_row = 0;
        cur_col = 0;
      end
      CMD_ROLL: begin
        n = (w.roll_rows > ROWS) ? ROWS : w.roll_rows;
        for (int i = 0; i < (ROWS - n) * COLS; i++) begin
          cells[i]   = cells[i + n * COLS];
          defined[i] = defined[i + n * COLS];
        end
        for (int i = (ROWS - n) * COLS; i < CELLS; i++) begin
          cells[i]   = BLANK_CELL;
          defined[i] = 1'b1;
        end
        // Even a roll by zero parks the cursor on the last row.
        cur_row = ROWS - 1;
      end
      CMD_READ: begin
        if (w.row >= ROWS || w.col >= COLS) begin
          res.status = 1'b1;
        end else begin
          idx           = w.row * COLS + w.col;
          res.read_char = cells[idx][7:0];
          res.read_attr = cells[idx][15:8];
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.cursor_row    = 5'(cur_row);
    res.cursor_col    = 7'(cur_col);
    res.cursor_offset = 11'(cur_row * COLS + cur_col);
    return res;
  endfunction

  function void note_command(in_word_t w);
    owed_results.push_back(apply_command(w));
  endfunction

  task compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      report($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    end
  endtask

  task check_result(out_word_t got);
    out_word_t want;
    if (owed_results.size() == 0) begin
      report($sformatf("result word 0x%0h arrived with no command pending", got));
      return;
    end
    want = owed_results.pop_front();
    compare_field("cursor_row", want.cursor_row, got.cursor_row);
    compare_field("cursor_col", want.cursor_col, got.cursor_col);
    compare_field("cursor_offset", want.cursor_offset, got.cursor_offset);
    compare_field("read_char", want.read_char, got.read_char);
    compare_field("read_attr", want.read_attr, got.read_attr);
    compare_field("status", want.status, got.status);
  endtask

endclass

[dv/testbench_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level of the console writer bench
// Runs a short directed sequence over the corner cases of the screen and the
// cursor, then bursts of random commands, with random gaps on the command
// side and a changing stall pattern on the result side.
// ----------------------------------------------------------------------------

module testbench;

  import tmcw_pkg::*;

  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 525;
  // Clear and roll up sweep the whole store, so the random part
  // issues a bounded number of them.
  localparam int SWEEP_CAP     = 40;
  // Slowest correct run: roughly 44 sweeps of the whole store plus 550 words,
  // each waiting out the longest command gap, the longest result stall and
  // the pipeline; the timeout allows about four times that.
  localparam int TIMEOUT_CYCLES = 600_000;
  localparam int DRAIN_CYCLES   = 10;

  localparam logic [2:0] CMD_UNUSED_LO = 3'(CMD_READ + 1);
  localparam logic [2:0] CMD_UNUSED_HI = 3'h7;

  typedef enum int {SINK_STEADY, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  in_word_t  in_word_i = '0;
  logic      full;
  logic      empty;
  logic      pop       = 1'b0;
  out_word_t out_word_o;

  screen_scoreboard sb;
  int unsigned      cycle_count = 0;
  int               sweeps_issued = 0;

  // Result side stall pattern state.
  sink_mode_e sink_mode      = SINK_STEADY;
  int         sink_left      = 0;
  int         sink_phase     = 0;
  int         sink_every     = 2;

  text_mode_console_writer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  // The watchdog ends a run that hangs, for example when a result word is
  // never produced.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge, before the block's own
  // registers update, so the model sees exactly the words that moved.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_command(in_word_i);
      end
      if (pop && !empty) begin
        sb.check_result(out_word_o);
      end
    end
  end

  // The receiver switches between stall patterns: always ready, a coin
  // toss per cycle, ready once every few cycles, and a long hold that ends
  // with a single pop. Each pattern lasts a random number of cycles.
  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode  = sink_mode_e'($urandom_range(SINK_STEADY, SINK_HOLD));
      sink_left  = $urandom_range(10, 80);
      sink_phase = 0;
      sink_every = $urandom_range(2, 6);
    end
    sink_left--;
    case (sink_mode)
      SINK_STEADY: begin
        pop <= 1'b1;
      end
      SINK_COIN: begin
        pop <= 1'($urandom_range(0, 1));
      end
      SINK_SPARSE: begin
        pop <= (sink_phase % sink_every) == 0;
        sink_phase++;
      end
      default: begin
        pop <= (sink_left == 0);
      end
    endcase
  end

  function automatic in_word_t make_word(logic [2:0] command, logic [7:0] char_code,
                                         logic [7:0] attribute, logic [4:0] row,
                                         logic [6:0] col, logic [7:0] roll_rows);
    in_word_t w;
    w.command   = command;
    w.char_code = char_code;
    w.attribute = attribute;
    w.row       = row;
    w.col       = col;
    w.roll_rows = roll_rows;
    return w;
  endfunction

  // Builds the next random command word from the model's current state, so
  // that reads only land on cells that hold defined content.
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    int       lin;
    w.char_code = 8'($urandom);
    w.attribute = 8'($urandom);
    w.row       = 5'($urandom);
    w.col       = 7'($urandom);
    w.roll_rows = 8'($urandom);
    pick        = $urandom_range(0, 99);
    if ((pick >= 90 && pick < 96) && sweeps_issued >= SWEEP_CAP) begin
      pick = 0;
    end
    if (pick < 50) begin
      w.command = CMD_WRITE;
    end else if (pick < 64) begin
      w.command = CMD_LOCATE;
      if ($urandom_range(0, 99) < 85) begin
        w.row = 5'($urandom_range(0, ROWS - 1));
        w.col = 7'($urandom_range(0, COLS - 1));
      end
    end else if (pick < 90) begin
      w.command = CMD_READ;
      pick      = $urandom_range(0, 99);
      if (pick < 50) begin
        // Read back the cell written most recently, just behind the cursor.
        lin = sb.cur_row * COLS + sb.cur_col - 1;
        if (lin < 0) begin
          lin += CELLS;
        end
        w.row = 5'(lin / COLS);
        w.col = 7'(lin % COLS);
      end else if (pick < 85) begin
        w.row = 5'($urandom_range(0, ROWS - 1));
        w.col = 7'($urandom_range(0, COLS - 1));
      end
      // A cell that was never written must not be read; turn such a read
      // into one with a row off the screen.
      if (w.row < ROWS && w.col < COLS && !sb.cell_defined(w.row, w.col)) begin
        w.row = 5'($urandom_range(ROWS, 31));
      end
    end else if (pick < 94) begin
      w.command = CMD_ROLL;
      if ($urandom_range(0, 99) < 70) begin
        w.roll_rows = 8'($urandom_range(0, 3));
      end
      sweeps_issued++;
    end else if (pick < 96) begin
      w.command = CMD_CLEAR;
      sweeps_issued++;
    end else begin
      w.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end
    return w;
  endfunction

  // Offers a word at a falling edge and holds it until the block takes it.
  // Returns at the falling edge after acceptance with push still high, so
  // a following word goes out without a gap.
  task send_word(in_word_t w);
    push      <= 1'b1;
    in_word_i <= w;
    do begin
      @(posedge clk_i);
    end while (full !== 1'b0);
    @(negedge clk_i);
  endtask

  task idle_cycles(int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Holds the command side until every owed result word has been popped.
  task wait_drained();
    push <= 1'b0;
    @(negedge clk_i);
    while (sb.owed_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    in_word_t directed [$];
    int       sent;
    int       burst;

    sb = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. After reset the cursor is home and the store is
    // undefined, so the first reads only touch cells written just before.
    directed.push_back(make_word(CMD_WRITE, 8'hFF, 8'hFF, 5'd0, 7'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0, 8'd0));
    // Reads off the screen, in row, in column, and at the field maxima.
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'(ROWS), 7'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'd0, 7'(COLS), 8'd0));
    directed.push_back(make_word(CMD_READ, 8'hFF, 8'hFF, 5'h1F, 7'h7F, 8'hFF));
    // A write into the last cell wraps the cursor back to the top.
    directed.push_back(make_word(CMD_LOCATE, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'd0));
    directed.push_back(make_word(CMD_WRITE, 8'h5A, 8'hA5, 5'd0, 7'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'd0));
    // A locate off the screen leaves the cursor where it was.
    directed.push_back(make_word(CMD_LOCATE, 8'h00, 8'h00, 5'h1F, 7'h7F, 8'd0));
    // A write at the end of a row wraps the column into the next row.
    directed.push_back(make_word(CMD_LOCATE, 8'h00, 8'h00, 5'd0, 7'(COLS - 1), 8'd0));
    directed.push_back(make_word(CMD_WRITE, 8'h00, 8'h00, 5'd0, 7'd0, 8'd0));
    // Unused command codes change nothing and answer an error.
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      directed.push_back(make_word(3'(c), 8'h00, 8'h00, 5'd0, 7'd0, 8'd0));
    end
    directed.push_back(make_word(CMD_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'd0));
    directed.push_back(make_word(CMD_LOCATE, 8'h00, 8'h00, 5'd3, 7'd10, 8'd0));
    directed.push_back(make_word(CMD_WRITE, 8'h41, 8'h1E, 5'd0, 7'd0, 8'd0));
    // A roll by zero moves no cell but still puts the cursor on the last row.
    directed.push_back(make_word(CMD_ROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'd3, 7'd10, 8'd0));
    directed.push_back(make_word(CMD_ROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'd1));
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'd2, 7'd10, 8'd0));
    // A roll count above the screen height is clamped and blanks it all.
    directed.push_back(make_word(CMD_ROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'hFF));
    directed.push_back(make_word(CMD_READ, 8'h00, 8'h00, 5'd2, 7'd10, 8'd0));
    directed.push_back(make_word(CMD_ROLL, 8'h00, 8'h00, 5'd0, 7'd0, 8'(ROWS - 1)));

    foreach (directed[i]) begin
      send_word(directed[i]);
      if ($urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 5));
      end
    end

    // Random part: bursts of back to back words separated by random gaps,
    // with the command side held twice until the block has fully drained.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_word(random_word());
        sent++;
        if (sent == RANDOM_ITEMS / 3 || sent == 2 * RANDOM_ITEMS / 3) begin
          wait_drained();
        end
      end
      if ($urandom_range(0, 9) >= 3) begin
        idle_cycles($urandom_range(1, 12));
      end
    end

    // Let every owed result word come out, then allow a few more cycles so
    // that a stray extra word would still be caught.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
